// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the time-weighted activity history RTL.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ----- rtl/core/twah_pkg.sv -----
// Package for the time-weighted activity history: opcodes, sequencer states,
// the control struct of the serial arithmetic unit and fixed-point limits.
// Depends on nothing.
`default_nettype none

package twah_pkg;

    localparam logic [2:0] OP_SAMPLE  = 3'd0;
    localparam logic [2:0] OP_RECORD  = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 64;

    localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;
    localparam logic [15:0] AVG_MAX = 16'h7FFF;
    localparam logic [15:0] AVG_MIN = 16'h8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_SAT,
        ST_HIST,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic divide;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/twah_serial_unit.sv -----
// Bit-serial arithmetic unit: shift-add multiply (16 x 32 bits, one bit a
// cycle) and restoring divide (64 by 32 bits, one quotient bit a cycle).
// Depends on twah_pkg.
`default_nettype none

module twah_serial_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire twah_pkg::unit_req_t req,
    output twah_pkg::unit_sts_t      sts,
    input  wire logic signed [15:0]  mul_value,
    input  wire logic [31:0]         mul_dt,
    input  wire logic [63:0]         div_mag,
    input  wire logic [31:0]         div_span,
    output logic signed [47:0]       product,
    output logic [15:0]              quotient,
    output logic                     quotient_big
);
    import twah_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic              div_mode_reg;
    logic [STEP_W-1:0] step_reg;

    logic [16:0] hi_reg;
    logic [31:0] lo_reg;
    logic [15:0] val_reg;

    logic [31:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [31:0] span_reg;
    logic [15:0] quo_reg;
    logic        big_reg;

    logic        last_step;
    logic [17:0] mul_sum;
    logic [32:0] div_shift;
    logic [33:0] div_diff;
    logic        div_ok;

    assign last_step = div_mode_reg ? (step_reg == STEP_W'(DIV_STEPS - 1))
                                    : (step_reg == STEP_W'(MUL_STEPS - 1));

    always_comb
    begin
        if (lo_reg[0])
        begin
            mul_sum = {hi_reg[16], hi_reg} + {{2{val_reg[15]}}, val_reg};
        end
        else
        begin
            mul_sum = {hi_reg[16], hi_reg};
        end
    end

    assign div_shift = {rem_reg, dvd_reg[63]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, span_reg};
    assign div_ok    = !div_diff[33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            div_mode_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg     <= 1'b1;
                div_mode_reg <= req.divide;
                step_reg     <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            if (req.divide)
            begin
                dvd_reg  <= div_mag;
                rem_reg  <= '0;
                span_reg <= div_span;
                quo_reg  <= '0;
                big_reg  <= 1'b0;
            end
            else
            begin
                hi_reg  <= '0;
                lo_reg  <= mul_dt;
                val_reg <= mul_value;
            end
        end
        else if (busy_reg)
        begin
            if (div_mode_reg)
            begin
                rem_reg <= div_ok ? div_diff[31:0] : div_shift[31:0];
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                quo_reg <= {quo_reg[14:0], div_ok};
                big_reg <= big_reg | quo_reg[15];
            end
            else
            begin
                hi_reg <= mul_sum[17:1];
                lo_reg <= {mul_sum[0], lo_reg[31:1]};
            end
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign product      = {hi_reg[15:0], lo_reg};
    assign quotient     = quo_reg;
    assign quotient_big = big_reg;

endmodule

`default_nettype wire

// ----- rtl/core/time_weighted_activity_history.sv -----
// Time-weighted activity history. One word in, one word out, one at a time.
// States per word: sample EXEC, MUL (32-step serial multiply), ACC, OUT; record
// EXEC, DIV (64-step serial divide), SAT, HIST, OUT; record over a zero span
// EXEC, HIST, OUT; read EXEC, READ (registered store read), OUT; others EXEC, OUT.
// IDLE takes a new word only after OUT has passed on the last one, and OUT waits
// on a busy sink. Reset is asynchronous: sum, times and count go to zero, no sweep.
`default_nettype none

module time_weighted_activity_history #(
    parameter int HISTORY_DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] sample_value, [47:16] time_ms, [50:48] entry_index, [55:51] zero
    input  wire logic [55:0] s_tdata,
    // [2:0] opcode
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] record_made, [16:1] average, [20:17] entry_count,
    // [21] history_full, [22] zero_interval, [23] zero
    output logic [23:0]      m_tdata
);
    import twah_pkg::*;

    // Entry count holds 0..DEPTH; pointers hold 0..DEPTH-1. Address sums stay
    // below twice the depth, so one compare and subtract wraps them.
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int AW    = ((PTR_W > 3) ? PTR_W : 3) + 1;
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

    state_t state_reg;
    state_t state_next;

    // Accepted word
    logic [2:0]  op_reg;
    logic [15:0] value_reg;
    logic [31:0] time_reg;
    logic [2:0]  idx_reg;

    // Accumulation state
    logic [63:0] sum_reg;
    logic [31:0] start_reg;
    logic [31:0] last_reg;
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;

    // Result under construction
    logic        res_made_reg;
    logic        res_zero_reg;
    logic [15:0] res_avg_reg;
    logic        sum_neg_reg;
    logic        rd_hit_reg;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    // History store, circular from head_reg
    logic [15:0]      hist_mem [HISTORY_DEPTH];
    logic [15:0]      mem_rdata_reg;
    logic             mem_we;
    logic             mem_re;
    logic [PTR_W-1:0] mem_waddr;
    logic [PTR_W-1:0] mem_raddr;

    unit_req_t          unit_req;
    unit_sts_t          unit_sts;
    logic signed [47:0] product;
    logic [15:0]        quotient;
    logic               quotient_big;

    logic        in_accept;
    logic        out_free;
    logic        full;
    logic [31:0] dt;
    logic [31:0] span;
    logic [63:0] sum_mag;
    logic [63:0] prod_ext;
    logic [63:0] sum_add;
    logic        sum_ovf;
    logic [63:0] sum_sat;
    logic        q_sat;
    logic [15:0] avg_sat;
    logic        rd_hit;
    logic [AW-1:0] raddr_sum;
    logic [AW-1:0] waddr_sum;
    logic [CNT_W+3:0] count_ext;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == CNT_W'(HISTORY_DEPTH));

    assign dt   = time_reg - last_reg;
    assign span = last_reg - start_reg;
    assign sum_mag = sum_reg[63] ? (64'd0 - sum_reg) : sum_reg;

    // Saturating accumulate of the finished product
    assign prod_ext = {{16{product[47]}}, product};
    assign sum_add  = sum_reg + prod_ext;
    assign sum_ovf  = (sum_reg[63] == prod_ext[63]) && (sum_add[63] != sum_reg[63]);
    assign sum_sat  = sum_ovf ? (sum_reg[63] ? SUM_MIN : SUM_MAX) : sum_add;

    // Clamp the magnitude quotient to Q1.15 and restore the sign
    assign q_sat = quotient_big || quotient[15];
    always_comb
    begin
        if (sum_neg_reg)
        begin
            avg_sat = q_sat ? AVG_MIN : (16'd0 - quotient);
        end
        else
        begin
            avg_sat = q_sat ? AVG_MAX : quotient;
        end
    end

    // Oldest entry sits at head_reg; wrap logical index to a store address
    assign rd_hit    = (CMP_W'(idx_reg) < CMP_W'(count_reg));
    assign raddr_sum = (AW'(head_reg) + AW'(idx_reg) >= AW'(HISTORY_DEPTH))
                       ? (AW'(head_reg) + AW'(idx_reg) - AW'(HISTORY_DEPTH))
                       : (AW'(head_reg) + AW'(idx_reg));
    assign waddr_sum = (AW'(head_reg) + AW'(count_reg) >= AW'(HISTORY_DEPTH))
                       ? (AW'(head_reg) + AW'(count_reg) - AW'(HISTORY_DEPTH))
                       : (AW'(head_reg) + AW'(count_reg));
    // When full the new entry overwrites the oldest, which is head_reg itself
    assign mem_waddr = full ? head_reg : waddr_sum[PTR_W-1:0];
    assign mem_raddr = raddr_sum[PTR_W-1:0];

    assign count_ext = {4'b0000, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        unit_req.start  = 1'b0;
        unit_req.divide = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_SAMPLE:
                    begin
                        unit_req.start = 1'b1;
                        state_next     = ST_MUL;
                    end
                    OP_RECORD:
                    begin
                        if (span == 32'd0)
                        begin
                            state_next = ST_HIST;
                        end
                        else
                        begin
                            unit_req.start  = 1'b1;
                            unit_req.divide = 1'b1;
                            state_next      = ST_DIV;
                        end
                    end
                    OP_READ:
                    begin
                        mem_re     = rd_hit;
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_MUL:
            begin
                if (unit_sts.done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = ST_OUT;
            end
            ST_DIV:
            begin
                if (unit_sts.done)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                state_next = ST_HIST;
            end
            ST_HIST:
            begin
                mem_we     = 1'b1;
                state_next = ST_OUT;
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Latch the accepted word and build the result fields
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg       <= s_tuser;
            value_reg    <= s_tdata[15:0];
            time_reg     <= s_tdata[47:16];
            idx_reg      <= s_tdata[50:48];
            res_made_reg <= 1'b0;
            res_zero_reg <= 1'b0;
            res_avg_reg  <= '0;
        end
        if (state_reg == ST_EXEC)
        begin
            sum_neg_reg <= sum_reg[63];
            rd_hit_reg  <= rd_hit;
            if (op_reg == OP_RECORD)
            begin
                res_made_reg <= 1'b1;
                res_zero_reg <= (span == 32'd0);
            end
        end
        if (state_reg == ST_SAT)
        begin
            res_avg_reg <= avg_sat;
        end
        if (state_reg == ST_READ)
        begin
            res_avg_reg <= rd_hit_reg ? mem_rdata_reg : 16'd0;
        end
    end

    // Accumulation and history bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            start_reg <= '0;
            last_reg  <= '0;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_EXEC)
            begin
                if (op_reg == OP_RESTART)
                begin
                    sum_reg   <= '0;
                    start_reg <= time_reg;
                    last_reg  <= time_reg;
                end
                else if (op_reg == OP_CLEAR)
                begin
                    head_reg  <= '0;
                    count_reg <= '0;
                end
            end
            if (state_reg == ST_ACC)
            begin
                sum_reg  <= sum_sat;
                last_reg <= time_reg;
            end
            if (state_reg == ST_HIST)
            begin
                sum_reg   <= '0;
                start_reg <= last_reg;
                if (full)
                begin
                    // drop the oldest entry
                    head_reg <= (head_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                : head_reg + 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= res_avg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= hist_mem[mem_raddr];
        end
    end

    // Output register: hold the word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {1'b0, res_zero_reg, full, count_ext[3:0],
                            res_avg_reg, res_made_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    twah_serial_unit u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (unit_req),
        .sts          (unit_sts),
        .mul_value    (value_reg),
        .mul_dt       (dt),
        .div_mag      (sum_mag),
        .div_span     (span),
        .product      (product),
        .quotient     (quotient),
        .quotient_big (quotient_big)
    );

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, (!rst_n || count_reg <= CNT_W'(HISTORY_DEPTH)), "entry count above depth")
    `ASSERT_CLK(a_unit_waited, ((state_reg == ST_MUL || state_reg == ST_DIV) |-> (unit_sts.busy || unit_sts.done)), "sequencer waits on idle unit")
    `ASSERT_CLK(a_done_expected, (unit_sts.done |-> (state_reg == ST_MUL || state_reg == ST_DIV)), "unit finished outside a wait state")
    `ASSERT_CLK(a_record_grows, ((state_reg == ST_HIST && !full) |=> (count_reg == $past(count_reg) + 1'b1)), "record did not grow history")

endmodule

`default_nettype wire
